/* design/hdgs_pkg.sv */
package hdgs_pkg;

  // Item opcodes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_STEP  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_ROWS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEF_COLS = 1'd1;

  // Field widths
  localparam int VAL_W   = 24;
  localparam int COEF_W  = 15;
  localparam int IDX_W   = 7;
  localparam int LAP_W   = VAL_W + 2;          // a + b - 2c
  localparam int PROD_W  = LAP_W + COEF_W + 1;  // signed product
  localparam int SUM_W   = PROD_W + 1;
  localparam int FRAC_W  = 16;                 // Q0.16 coefficients
  localparam int DELTA_W = SUM_W - FRAC_W;
  localparam int NEW_W   = DELTA_W + 1;

  localparam logic [COEF_W-1:0] COEF_RESET = 15'd8192;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = -24'sh800000;

  typedef logic signed [VAL_W-1:0] cell_t;
  typedef logic signed [LAP_W-1:0] lap_t;

  // Sweep slot tags
  localparam logic [1:0] TAG_PRIME = 2'd0;  // fetch first cell of a row
  localparam logic [1:0] TAG_UD    = 2'd1;  // fetch up and down neighbors
  localparam logic [1:0] TAG_RT    = 2'd2;  // fetch right neighbor

  // a + b - 2c on sign-extended operands
  function automatic lap_t lap3(cell_t a, cell_t b, cell_t c);
    lap_t ae;
    lap_t be;
    lap_t ce;
    ae = LAP_W'(a);
    be = LAP_W'(b);
    ce = LAP_W'(c);
    return ae + be - (ce <<< 1);
  endfunction

endpackage

/* design/heat_diffusion_grid_step_core.sv */
// Explicit five-point heat diffusion on a GRID_SIDE x GRID_SIDE grid of signed
// Q15.8 temperatures held in on-chip RAM (two banks that swap roles each step).
// A write transfer loads one cell, a read transfer returns one cell through
// the output register, and a step transfer sweeps the whole grid in raster
// order: each cell needs three RAM reads over a two-port read side (up and
// down, then right; left and center are kept from the previous cell) and
// both coefficient products go through one shared 26x16 multiplier, one
// product per cycle. Each row starts with a fetch of its first cell. Edge
// cells are copied unchanged; interior results are floor-shifted and
// saturated to 24 bits. After reset the grid is cleared to zero by a pass
// over every cell, during which in_stall stays high (configuration writes
// are taken as usual). in_stall is high while any item is in progress; a
// finished read waits in the output register without blocking the next
// transfer. Out-of-range writes are dropped, out-of-range reads return
// zero, and opcode 3 is ignored.
module heat_diffusion_grid_step_core
  import hdgs_pkg::*;
#(
  parameter int GRID_SIDE = 128
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // configuration
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [COEF_W-1:0]      cfg_wr_data,
  // input channel
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [1:0]             in_opcode,
  input  logic [IDX_W-1:0]       in_row,
  input  logic [IDX_W-1:0]       in_col,
  input  logic signed [VAL_W-1:0] in_cell_value,
  // result channel
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic signed [VAL_W-1:0] out_read_value
);

  localparam int CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int SIDE_W = $clog2(GRID_SIDE);
  localparam logic [SIDE_W-1:0] SIDE_LAST = SIDE_W'(GRID_SIDE - 1);
  localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] ROW_STEP  = ADDR_W'(GRID_SIDE);

  // Controller states
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_DRAIN = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [COEF_W-1:0] coef_rows_r, coef_cols_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_rows_r <= COEF_RESET;
      coef_cols_r <= COEF_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_COEF_ROWS: coef_rows_r <= cfg_wr_data;
        CFG_COEF_COLS: coef_cols_r <= cfg_wr_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Item decode
  // ---------------------------------------------------------------------------
  logic              in_xfer;
  logic              item_inside;
  logic [ADDR_W-1:0] item_addr;

  assign in_xfer     = in_valid && !in_stall;
  assign item_inside = (32'(in_row) < GRID_SIDE) && (32'(in_col) < GRID_SIDE);
  assign item_addr   = ADDR_W'(32'(in_row) * GRID_SIDE + 32'(in_col));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  logic [2:0]        state_r, state_nxt;
  logic              cur_r, cur_nxt;        // bank holding the current grid
  logic [ADDR_W-1:0] cidx_r, cidx_nxt;      // clear pointer / sweep cell
  logic [SIDE_W-1:0] row_r, row_nxt;
  logic [SIDE_W-1:0] col_r, col_nxt;
  logic [1:0]        slot_r, slot_nxt;
  logic              rd_inside_r;
  logic              out_valid_r, out_valid_nxt;
  cell_t             out_value_r;

  logic st1_vld_r, st2_vld_r, st3_vld_r;
  logic out_load;

  assign in_stall = (state_r != S_IDLE);
  assign out_load = (state_r == S_READ) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    cidx_nxt  = cidx_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    slot_nxt  = slot_r;
    case (state_r)
      S_CLEAR: begin
        cidx_nxt = cidx_r + 1'b1;
        if (cidx_r == CELL_LAST) begin
          cidx_nxt  = '0;
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_xfer && in_opcode == OP_STEP) begin
          state_nxt = S_STEP;
          cidx_nxt  = '0;
          row_nxt   = '0;
          col_nxt   = '0;
          slot_nxt  = TAG_PRIME;
        end else if (in_xfer && in_opcode == OP_READ) begin
          state_nxt = S_READ;
        end
      end
      S_STEP: begin
        case (slot_r)
          TAG_PRIME: slot_nxt = TAG_UD;
          TAG_UD:    slot_nxt = TAG_RT;
          default: begin
            // advance to the next cell once its right neighbor is issued
            cidx_nxt = cidx_r + 1'b1;
            if (col_r == SIDE_LAST) begin
              col_nxt  = '0;
              slot_nxt = TAG_PRIME;
              if (row_r == SIDE_LAST) begin
                state_nxt = S_DRAIN;
              end else begin
                row_nxt = row_r + 1'b1;
              end
            end else begin
              col_nxt  = col_r + 1'b1;
              slot_nxt = TAG_UD;
            end
          end
        endcase
      end
      S_DRAIN: begin
        // swap banks once the last result is in RAM
        if (!st1_vld_r && !st2_vld_r && !st3_vld_r) begin
          cur_nxt   = !cur_r;
          state_nxt = S_IDLE;
        end
      end
      S_READ: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      cur_r   <= 1'b0;
      cidx_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
      slot_r  <= TAG_PRIME;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      cidx_r  <= cidx_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      slot_r  <= slot_nxt;
    end
  end

  // Issue addresses; edge reads are clamped to the cell itself
  logic              iss_edge;
  logic [ADDR_W-1:0] iss_up, iss_dn, iss_rt;

  assign iss_edge = (row_r == '0) || (row_r == SIDE_LAST) ||
                    (col_r == '0) || (col_r == SIDE_LAST);
  assign iss_up   = (row_r == '0)        ? cidx_r : cidx_r - ROW_STEP;
  assign iss_dn   = (row_r == SIDE_LAST) ? cidx_r : cidx_r + ROW_STEP;
  assign iss_rt   = (col_r == SIDE_LAST) ? cidx_r : cidx_r + 1'b1;

  // ---------------------------------------------------------------------------
  // Grid RAM: two banks, one write port, two registered read ports
  // The bank is the top address bit, so bank 1 starts at 2**ADDR_W.
  // ---------------------------------------------------------------------------
  cell_t grid_mem_r [0:(2**ADDR_W)+CELLS-1];

  logic              mem_we;
  logic [ADDR_W:0]   mem_waddr;
  cell_t             mem_wdata;
  logic              mem_re_a;
  logic [ADDR_W:0]   mem_raddr_a, mem_raddr_b;
  cell_t             rd_a_r, rd_b_r;

  logic [ADDR_W-1:0] st3_idx_r;
  cell_t             new_val;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {cur_r, item_addr};
    mem_wdata = in_cell_value;
    if (state_r == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = {1'b0, cidx_r};
      mem_wdata = '0;
    end else if (st3_vld_r) begin
      mem_we    = 1'b1;
      mem_waddr = {!cur_r, st3_idx_r};
      mem_wdata = new_val;
    end else if (in_xfer && in_opcode == OP_WRITE && item_inside) begin
      mem_we = 1'b1;
    end
  end

  always_comb begin
    mem_raddr_a = {cur_r, item_addr};
    mem_raddr_b = {cur_r, iss_dn};
    if (state_r == S_STEP) begin
      case (slot_r)
        TAG_PRIME: mem_raddr_a = {cur_r, cidx_r};
        TAG_UD:    mem_raddr_a = {cur_r, iss_up};
        default:   mem_raddr_a = {cur_r, iss_rt};
      endcase
    end
  end

  // hold port A data while a read waits for the output register
  assign mem_re_a = (state_r != S_READ);

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem_r[mem_waddr] <= mem_wdata;
    if (mem_re_a) rd_a_r <= grid_mem_r[mem_raddr_a];
    rd_b_r <= grid_mem_r[mem_raddr_b];
  end

  // ---------------------------------------------------------------------------
  // Stencil datapath
  //   st1: RAM data back; form up+down-2c or left+right-2c, shift the window
  //   st2: second product added to the first through the shared multiplier
  //   st3: floor shift, add center, saturate, write the other bank
  // ---------------------------------------------------------------------------
  logic [1:0]        st1_tag_r;
  logic [ADDR_W-1:0] st1_idx_r, st2_idx_r;
  logic              st1_edge_r, st2_edge_r, st3_edge_r;
  cell_t             lft_r, ctr_r, st2_ctr_r, st3_ctr_r;
  lap_t              dr_r, dc_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [SUM_W-1:0]  sum_r;

  logic st1_rt;
  assign st1_rt = st1_vld_r && (st1_tag_r == TAG_RT);

  // Shared multiplier: row term while st1 holds a right fetch, else column term
  lap_t                     mul_a;
  logic [COEF_W-1:0]        mul_b;
  logic signed [PROD_W-1:0] mul_p;

  assign mul_a = st1_rt ? dr_r : dc_r;
  assign mul_b = st1_rt ? coef_rows_r : coef_cols_r;
  assign mul_p = PROD_W'(mul_a) * $signed(PROD_W'({1'b0, mul_b}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
      st3_vld_r <= 1'b0;
    end else begin
      st1_vld_r <= (state_r == S_STEP);
      st2_vld_r <= st1_rt;
      st3_vld_r <= st2_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    st1_tag_r  <= slot_r;
    st1_idx_r  <= cidx_r;
    st1_edge_r <= iss_edge;
    if (st1_vld_r) begin
      case (st1_tag_r)
        TAG_PRIME: ctr_r <= rd_a_r;
        TAG_UD:    dr_r  <= lap3(rd_a_r, rd_b_r, ctr_r);
        default: begin
          dc_r       <= lap3(lft_r, rd_a_r, ctr_r);
          lft_r      <= ctr_r;
          ctr_r      <= rd_a_r;
          prod_r     <= mul_p;
          st2_idx_r  <= st1_idx_r;
          st2_edge_r <= st1_edge_r;
          st2_ctr_r  <= ctr_r;
        end
      endcase
    end
    if (st2_vld_r) begin
      sum_r      <= SUM_W'(prod_r) + SUM_W'(mul_p);
      st3_idx_r  <= st2_idx_r;
      st3_edge_r <= st2_edge_r;
      st3_ctr_r  <= st2_ctr_r;
    end
  end

  // Arithmetic shift right floors; saturate when the top bits disagree
  logic signed [DELTA_W-1:0] delta;
  logic signed [NEW_W-1:0]   new_wide;

  assign delta    = sum_r[SUM_W-1:FRAC_W];
  assign new_wide = NEW_W'(st3_ctr_r) + NEW_W'(delta);

  always_comb begin
    if (st3_edge_r) begin
      new_val = st3_ctr_r;
    end else if (new_wide[NEW_W-1:VAL_W-1] != {(NEW_W-VAL_W+1){new_wide[VAL_W-1]}}) begin
      new_val = new_wide[NEW_W-1] ? VAL_MIN : VAL_MAX;
    end else begin
      new_val = new_wide[VAL_W-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Read result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_xfer) rd_inside_r <= item_inside;
    if (out_load) out_value_r <= rd_inside_r ? rd_a_r : '0;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_value_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_mul_one_user: assert property (@(posedge clk) disable iff (!rst_n)
    !(st1_rt && st2_vld_r))
    else $error("shared multiplier claimed by two stages");

  a_bank_swap_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_r != $past(cur_r)) |-> ($past(state_r) == S_DRAIN && !$past(st3_vld_r)))
    else $error("bank swap before the sweep drained");

  a_sweep_write_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    st3_vld_r |-> (state_r == S_STEP || state_r == S_DRAIN))
    else $error("stencil write outside a step");

  a_read_next_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_opcode == OP_READ) |=> (state_r == S_READ))
    else $error("read transfer did not start a RAM read");

  a_result_from_read: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_READ))
    else $error("result presented without a read");

endmodule

/* verif/testbench.sv */
module testbench;
  import hdgs_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int GRID_SIDE = 128;
  // Opcode that the block must ignore without producing a result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  // Give up after this many cycles
  localparam int CYCLE_LIMIT = 3_000_000;
  // Length of the one long receiver hold-off
  localparam int LONG_HOLD = 400;
  // Steps allowed in one random batch
  localparam int STEPS_PER_BATCH = 4;

  typedef struct {
    logic [1:0]       opcode;
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    cell_t            value;
    bit               wait_drain;  // hold this transfer until all reads are back
  } grid_item_t;

  typedef struct {
    logic [IDX_W-1:0] row;
    logic [IDX_W-1:0] col;
    cell_t            value;
  } read_due_t;

  logic clk;
  logic rst_n = 1'b0;

  logic                    cfg_wr_en   = 1'b0;
  logic [CFG_IDX_W-1:0]    cfg_index   = CFG_COEF_ROWS;
  logic [COEF_W-1:0]       cfg_wr_data = '0;

  logic                    in_valid      = 1'b0;
  logic                    in_stall;
  logic [1:0]              in_opcode     = OP_WRITE;
  logic [IDX_W-1:0]        in_row        = '0;
  logic [IDX_W-1:0]        in_col        = '0;
  logic signed [VAL_W-1:0] in_cell_value = '0;

  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_read_value;

  heat_diffusion_grid_step_core #(
    .GRID_SIDE(GRID_SIDE)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_index     (cfg_index),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_row        (in_row),
    .in_col        (in_col),
    .in_cell_value (in_cell_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_read_value(out_read_value)
  );

  // Predicted grid, its scratch copy for a step, and the coefficients in force
  cell_t             grid_model   [GRID_SIDE][GRID_SIDE];
  cell_t             grid_scratch [GRID_SIDE][GRID_SIDE];
  logic [COEF_W-1:0] coef_rows_model;
  logic [COEF_W-1:0] coef_cols_model;

  grid_item_t items_to_send [$];  // transfers not yet offered to the block
  read_due_t  reads_due [$];      // predicted read results, oldest first
  grid_item_t cur_item;           // transfer currently offered on the input

  int error_count = 0;
  int cycle_count = 0;
  int snd_idle_pct = 0;
  int rcv_idle_pct = 0;
  int phase_no = 0;
  int hold_left = 0;
  bit long_hold_done = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic flag_error(string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  // One explicit diffusion step over the predicted grid. Every cell reads the
  // grid as it stood before the step; the border rows and columns stay put.
  task automatic advance_grid_model();
    longint cv, dr, dc, acc;
    for (int r = 0; r < GRID_SIDE; r++) begin
      for (int c = 0; c < GRID_SIDE; c++) begin
        cv = grid_model[r][c];
        if (r > 0 && r < GRID_SIDE - 1 && c > 0 && c < GRID_SIDE - 1) begin
          dr  = longint'(grid_model[r-1][c]) + longint'(grid_model[r+1][c]) - 2 * cv;
          dc  = longint'(grid_model[r][c-1]) + longint'(grid_model[r][c+1]) - 2 * cv;
          acc = longint'(coef_rows_model) * dr + longint'(coef_cols_model) * dc;
          // arithmetic shift on a signed value rounds toward minus infinity
          cv  = cv + (acc >>> FRAC_W);
          if (cv > longint'(VAL_MAX)) cv = VAL_MAX;
          if (cv < longint'(VAL_MIN)) cv = VAL_MIN;
        end
        grid_scratch[r][c] = cell_t'(cv);
      end
    end
    grid_model = grid_scratch;
  endtask

  // Apply one accepted transfer to the predicted state
  task automatic predict_transfer(grid_item_t it);
    case (it.opcode)
      OP_WRITE: grid_model[it.row][it.col] = it.value;
      OP_STEP:  advance_grid_model();
      OP_READ:  reads_due.push_back('{row: it.row, col: it.col,
                                      value: grid_model[it.row][it.col]});
      default: ;  // unused opcode: drop without effect
    endcase
  endtask

  // Input driver: hold an offered transfer until taken, then either advance to
  // the next pending item or leave the input idle.
  always @(posedge clk) begin
    grid_item_t nxt;
    bit taken;
    bit idle_now;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) predict_transfer(cur_item);
      if (!in_valid || taken) begin
        idle_now = ($urandom_range(99) < snd_idle_pct);
        if (items_to_send.size() != 0 && !idle_now &&
            !(items_to_send[0].wait_drain && reads_due.size() != 0)) begin
          nxt = items_to_send.pop_front();
          cur_item      <= nxt;
          in_valid      <= 1'b1;
          in_opcode     <= nxt.opcode;
          in_row        <= nxt.row;
          in_col        <= nxt.col;
          in_cell_value <= nxt.value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off: once in the last phase, stall the result side for a long
  // stretch so that a finished read sits in the output register and the next
  // read backs up into the input.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (phase_no == 3 && !long_hold_done && out_valid) begin
      hold_left      <= LONG_HOLD;
      long_hold_done <= 1'b1;
    end
  end

  // Result monitor: compare every transfer on the output with the oldest
  // predicted read, then pick the stall for the next cycle.
  always @(posedge clk) begin
    read_due_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reads_due.size() == 0) begin
          flag_error($sformatf("read result %0d with no read outstanding", out_read_value));
        end else begin
          want = reads_due.pop_front();
          if (out_read_value !== want.value)
            flag_error($sformatf("read (%0d,%0d): got %0d, want %0d",
                                 want.row, want.col, out_read_value, want.value));
        end
      end
      out_stall <= (hold_left != 0) || ($urandom_range(99) < rcv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d reads outstanding", cycle_count,
               reads_due.size());
      $display("** heat_diffusion_grid_step_core: FAILED **");
      $finish;
    end
  end

  task automatic queue_item(logic [1:0] op, int r, int c, cell_t v, bit drain = 1'b0);
    grid_item_t it;
    it.opcode     = op;
    it.row        = IDX_W'(r);
    it.col        = IDX_W'(c);
    it.value      = v;
    it.wait_drain = drain;
    items_to_send.push_back(it);
  endtask

  // Load a center cell and its four neighbors
  task automatic queue_cross(int r, int c, cell_t center, cell_t ring);
    queue_item(OP_WRITE, r, c, center);
    queue_item(OP_WRITE, r - 1, c, ring);
    queue_item(OP_WRITE, r + 1, c, ring);
    queue_item(OP_WRITE, r, c - 1, ring);
    queue_item(OP_WRITE, r, c + 1, ring);
  endtask

  // Temperatures biased toward the range ends and small values near zero
  function automatic cell_t pick_temperature();
    case ($urandom_range(5))
      0:       return VAL_MAX;
      1:       return VAL_MIN;
      2:       return cell_t'(int'($urandom_range(511)) - 256);
      default: return cell_t'($urandom);
    endcase
  endfunction

  // Random batch: mostly writes and reads clustered in a 6x6 window so that
  // steps mix loaded cells and reads land on them, with a few transfers
  // anywhere on the grid and some unused opcodes. End on a read so the block
  // is idle once its result is back.
  task automatic queue_random_items(int count, int base_r, int base_c);
    int pick;
    int steps;
    bit drain;
    steps = 0;
    repeat (count) begin
      pick  = $urandom_range(99);
      drain = ($urandom_range(29) == 0);
      if (pick < 40) begin
        queue_item(OP_WRITE, base_r + $urandom_range(5), base_c + $urandom_range(5),
                   pick_temperature(), drain);
      end else if (pick < 72) begin
        queue_item(OP_READ, base_r + $urandom_range(5), base_c + $urandom_range(5),
                   cell_t'($urandom), drain);
      end else if (pick < 80) begin
        if (steps < STEPS_PER_BATCH) begin
          queue_item(OP_STEP, $urandom_range(127), $urandom_range(127),
                     cell_t'($urandom), drain);
          steps++;
        end else begin
          queue_item(OP_READ, base_r + $urandom_range(5), base_c + $urandom_range(5),
                     cell_t'($urandom), drain);
        end
      end else if (pick < 85) begin
        queue_item(OP_UNUSED, $urandom_range(127), $urandom_range(127),
                   cell_t'($urandom), drain);
      end else if (pick < 93) begin
        queue_item(OP_WRITE, $urandom_range(127), $urandom_range(127),
                   cell_t'($urandom), drain);
      end else begin
        queue_item(OP_READ, $urandom_range(127), $urandom_range(127),
                   cell_t'($urandom), drain);
      end
    end
    queue_item(OP_READ, base_r + $urandom_range(5), base_c + $urandom_range(5), '0);
  endtask

  // Wait until every pending transfer is taken and every read is back
  task automatic wait_idle();
    while (items_to_send.size() != 0 || in_valid || reads_due.size() != 0)
      @(posedge clk);
    // the last transfer was a read, so the block is idle once its result is back
    repeat (8) @(posedge clk);
  endtask

  task automatic write_coef(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= val;
    if (idx == CFG_COEF_ROWS) coef_rows_model = val;
    else coef_cols_model = val;
  endtask

  task automatic set_coefs(logic [COEF_W-1:0] rows_val, logic [COEF_W-1:0] cols_val);
    write_coef(CFG_COEF_ROWS, rows_val);
    write_coef(CFG_COEF_COLS, cols_val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    for (int r = 0; r < GRID_SIDE; r++)
      for (int c = 0; c < GRID_SIDE; c++)
        grid_model[r][c] = '0;
    coef_rows_model = COEF_RESET;
    coef_cols_model = COEF_RESET;

    repeat (5) @(posedge clk);
    rst_n        <= 1'b1;
    snd_idle_pct <= 30;
    rcv_idle_pct <= 49;

    // Directed pass at the reset coefficients: cleared grid, the four corners
    // with both range ends, an unused opcode that must not write, a cross of
    // extreme values, a small negative cell for floor rounding, fixed edges.
    queue_item(OP_READ, 0, 0, '0);
    queue_item(OP_WRITE, 0, 0, VAL_MAX);
    queue_item(OP_WRITE, 127, 127, VAL_MIN);
    queue_item(OP_WRITE, 0, 127, 24'sh5A5A5A);
    queue_item(OP_WRITE, 127, 0, -24'sd1);
    queue_item(OP_READ, 127, 127, '0);
    queue_item(OP_READ, 0, 127, '0);
    queue_item(OP_READ, 127, 0, '0);
    queue_cross(64, 64, VAL_MAX, VAL_MIN);
    queue_item(OP_UNUSED, 64, 64, '0);
    queue_item(OP_READ, 64, 64, '0);
    queue_item(OP_WRITE, 0, 1, VAL_MAX);
    queue_item(OP_WRITE, 1, 1, -24'sd3);
    queue_item(OP_STEP, 0, 0, '0);
    queue_item(OP_READ, 64, 64, '0);
    queue_item(OP_READ, 63, 64, '0);
    queue_item(OP_READ, 0, 0, '0, 1'b1);
    queue_item(OP_READ, 1, 1, '0);
    queue_item(OP_READ, 62, 64, '0);
    queue_item(OP_STEP, 127, 127, '1);
    queue_item(OP_READ, 64, 64, '0);
    wait_idle();

    // Rows at the stability limit, columns off; window on the corner edges
    phase_no <= 1;
    set_coefs(15'd16384, 15'd0);
    queue_random_items(20, 0, 0);
    wait_idle();

    // Both coefficients at their widest, well past stability: saturation
    phase_no     <= 2;
    snd_idle_pct <= 49;
    rcv_idle_pct <= 30;
    set_coefs(15'd32767, 15'd32767);
    queue_cross(100, 100, VAL_MIN, VAL_MAX);
    queue_item(OP_STEP, 0, 0, '0);
    queue_item(OP_READ, 100, 100, '0);
    queue_item(OP_READ, 99, 100, '0);
    queue_random_items(20, 60, 122);
    wait_idle();

    // No idling on either side, plus the long receiver hold-off
    phase_no     <= 3;
    snd_idle_pct <= 0;
    rcv_idle_pct <= 0;
    set_coefs(15'd0, 15'd16384);
    queue_random_items(25, 122, 40);
    wait_idle();

    repeat (20) @(posedge clk);
    if (reads_due.size() != 0)
      flag_error($sformatf("%0d predicted reads never returned", reads_due.size()));
    if (error_count == 0) begin
      $display("** heat_diffusion_grid_step_core: PASSED **");
    end else begin
      $display("** heat_diffusion_grid_step_core: FAILED **");
    end
    $finish;
  end

endmodule
